[src/sha1_pkg.sv]
// Shared types, constants and helpers for the SHA-1 engine.
package sha1_pkg;

  localparam int unsigned BlockWords  = 16;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned Rounds      = 80;

  localparam logic [31:0] H_INIT [DigestWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTES,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  // Where to go once a compression has been folded into the chain
  typedef enum logic [1:0] {
    PH_BYTES,
    PH_PAD,
    PH_LEN
  } phase_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    rotl5 = {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    rotl30 = {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    rotl1 = {x[30:0], x[31]};
  endfunction

endpackage

[src/sha1_round.sv]
// One SHA-1 round: the shared unit stepped eighty times per block.
module sha1_round
  import sha1_pkg::*;
(
  input  work_t       cur_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  round_i,
  output work_t       nxt_o
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round_i < 7'd20) begin
      f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      k = K0;
    end else if (round_i < 7'd40) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K1;
    end else if (round_i < 7'd60) begin
      f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
      k = K2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K3;
    end
  end

  always_comb begin
    nxt_o.a = rotl5(cur_i.a) + f + cur_i.e + w_i + k;
    nxt_o.b = cur_i.a;
    nxt_o.c = rotl30(cur_i.b);
    nxt_o.d = cur_i.c;
    nxt_o.e = cur_i.d;
  end

endmodule

[src/sha1_hash_engine_core.sv]
// SHA-1 engine: byte packing, padding sequencer, round loop and digest output.
//
// One input beat carries a big-endian word with a count of valid leading bytes
// and an end-of-message flag in tlast. The engine is busy while it works and
// drops s_axis_tready_o. Bytes are packed into the 16-word block buffer one per
// cycle, pausing while a full block is compressed. Each full block runs through
// a single shared round unit, one round per cycle, followed by a step that folds
// the result into the chaining words. At end of message the 0x80 marker and zero
// bytes are placed one per cycle up to byte 56, pausing for a compression when a
// second block is needed; then the length words are written, the final block is
// compressed, and the five digest words leave as five output beats, index 0
// first, tlast on the fifth. No clearing is needed after reset; the engine
// restarts from the initial values after each digest.
module sha1_hash_engine_core
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] data_word, [34:32] valid_bytes
  input  logic        s_axis_tlast_i,  // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [31:0] digest_word, [34:32] digest_index
  output logic        m_axis_tlast_o   // last
);

  state_e      st_q, st_d;
  phase_e      ph_q, ph_d;
  logic [31:0] data_q;
  logic [2:0]  cnt_q;
  logic [2:0]  bidx_q;
  logic        eom_q;
  logic        pad_first_q;
  logic [5:0]  pos_q;
  logic [63:0] len_q;
  logic [6:0]  round_q;
  logic [2:0]  oidx_q;
  logic [31:0] chain_q [DigestWords];
  work_t       work_q;
  work_t       work_nxt;
  logic [31:0] buf_q [BlockWords];
  logic [31:0] w_new;

  logic        accept;
  logic        put_en;
  logic [7:0]  put_byte;
  logic        bytes_step;
  logic        load_work;
  logic        round_en;
  logic        add_en;
  logic        len_wr;
  logic        out_inc;
  logic        restart;
  logic [7:0]  data_byte;
  logic [2:0]  cnt_in;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign cnt_in = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];

  always_comb begin
    case (bidx_q[1:0])
      2'd0:    data_byte = data_q[31:24];
      2'd1:    data_byte = data_q[23:16];
      2'd2:    data_byte = data_q[15:8];
      default: data_byte = data_q[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ph_q <= PH_BYTES;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
    end
  end

  always_comb begin
    st_d            = st_q;
    ph_d            = ph_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    put_en          = 1'b0;
    put_byte        = data_byte;
    bytes_step      = 1'b0;
    load_work       = 1'b0;
    round_en        = 1'b0;
    add_en          = 1'b0;
    len_wr          = 1'b0;
    out_inc         = 1'b0;
    restart         = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) st_d = ST_BYTES;
      end
      ST_BYTES: begin
        if (bidx_q != cnt_q) begin
          put_en     = 1'b1;
          bytes_step = 1'b1;
          if (pos_q == 6'd63) begin
            load_work = 1'b1;
            ph_d      = PH_BYTES;
            st_d      = ST_COMP;
          end
        end else if (eom_q) begin
          st_d = ST_PAD;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (!pad_first_q && pos_q == 6'd56) begin
          st_d = ST_LEN;
        end else begin
          put_en   = 1'b1;
          put_byte = pad_first_q ? PAD_BYTE : 8'h00;
          if (pos_q == 6'd63) begin
            load_work = 1'b1;
            ph_d      = PH_PAD;
            st_d      = ST_COMP;
          end
        end
      end
      ST_LEN: begin
        len_wr    = 1'b1;
        load_work = 1'b1;
        ph_d      = PH_LEN;
        st_d      = ST_COMP;
      end
      ST_COMP: begin
        round_en = 1'b1;
        if (round_q == 7'(Rounds - 1)) st_d = ST_ADD;
      end
      ST_ADD: begin
        add_en = 1'b1;
        unique case (ph_q)
          PH_BYTES: st_d = ST_BYTES;
          PH_PAD:   st_d = ST_PAD;
          PH_LEN:   st_d = ST_OUT;
          default:  st_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (oidx_q == 3'(DigestWords - 1)) begin
            restart = 1'b1;
            st_d    = ST_IDLE;
          end else begin
            out_inc = 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Latch the incoming beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= s_axis_tdata_i[31:0];
      cnt_q  <= cnt_in;
      eom_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidx_q      <= '0;
      pad_first_q <= 1'b0;
      pos_q       <= '0;
      len_q       <= '0;
      round_q     <= '0;
      oidx_q      <= '0;
    end else begin
      if (accept) begin
        bidx_q      <= '0;
        pad_first_q <= 1'b1;
      end else if (bytes_step) begin
        bidx_q <= bidx_q + 3'd1;
      end
      if (put_en && st_q == ST_PAD) pad_first_q <= 1'b0;
      if (restart || len_wr) begin
        pos_q <= '0;
      end else if (put_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (restart) begin
        len_q <= '0;
      end else if (bytes_step) begin
        len_q <= len_q + 64'd8;
      end
      if (load_work) begin
        round_q <= '0;
      end else if (round_en) begin
        round_q <= round_q + 7'd1;
      end
      if (restart) begin
        oidx_q <= '0;
      end else if (out_inc) begin
        oidx_q <= oidx_q + 3'd1;
      end
    end
  end

  assign w_new = rotl1(buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0]);

  // Block buffer: byte writes while filling, length words at the end, shift one word per round
  always_ff @(posedge clk_i) begin
    if (round_en) begin
      for (int i = 0; i < BlockWords - 1; i++) buf_q[i] <= buf_q[i + 1];
      buf_q[BlockWords - 1] <= w_new;
    end else if (len_wr) begin
      buf_q[14] <= len_q[63:32];
      buf_q[15] <= len_q[31:0];
    end else if (put_en) begin
      unique case (pos_q[1:0])
        2'd0: buf_q[pos_q[5:2]] <= {put_byte, 24'h000000};
        2'd1: buf_q[pos_q[5:2]] <= buf_q[pos_q[5:2]] | {8'h00, put_byte, 16'h0000};
        2'd2: buf_q[pos_q[5:2]] <= buf_q[pos_q[5:2]] | {16'h0000, put_byte, 8'h00};
        default: buf_q[pos_q[5:2]] <= buf_q[pos_q[5:2]] | {24'h000000, put_byte};
      endcase
    end
  end

  sha1_round u_round (
    .cur_i   (work_q),
    .w_i     (buf_q[0]),
    .round_i (round_q),
    .nxt_o   (work_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      for (int i = 0; i < DigestWords; i++) chain_q[i] <= H_INIT[i];
    end else if (restart) begin
      work_q <= '0;
      for (int i = 0; i < DigestWords; i++) chain_q[i] <= H_INIT[i];
    end else if (load_work) begin
      work_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
                  d: chain_q[3], e: chain_q[4]};
    end else if (round_en) begin
      work_q <= work_nxt;
    end else if (add_en) begin
      chain_q[0] <= chain_q[0] + work_q.a;
      chain_q[1] <= chain_q[1] + work_q.b;
      chain_q[2] <= chain_q[2] + work_q.c;
      chain_q[3] <= chain_q[3] + work_q.d;
      chain_q[4] <= chain_q[4] + work_q.e;
    end
  end

  assign m_axis_tdata_o = {5'b00000, oidx_q, chain_q[oidx_q]};
  assign m_axis_tlast_o = (oidx_q == 3'(DigestWords - 1));

endmodule

[src/sha1_checker.sv]
// Port-level checks for the SHA-1 engine, bound to the top level.
module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled digest beat changed");

  // The engine takes no input while digest words are pending
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while digest pending");

  // tlast marks exactly the fifth word
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd4)))
    else $error("tlast does not match digest index");

  // After the final beat the engine is idle again
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=>
      !m_axis_tvalid_o && s_axis_tready_o)
    else $error("engine not idle after final digest beat");

  // A new digest starts at index zero
  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> m_axis_tdata_o[34:32] == 3'd0)
    else $error("digest did not start at index zero");

endmodule

bind sha1_hash_engine_core sha1_checker u_sha1_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[bench/sha1_hash_engine_core_tb.sv]
// Self-checking bench for the SHA-1 engine: directed messages, random messages, digest checks.
module testbench
  import sha1_pkg::*;
();

  localparam int unsigned RandomBeats = 120;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic [31:0]  data;
    logic [2:0]   count;
    logic         eom;
    logic         known;
    logic [159:0] digest;
  } msg_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // [31:0] data_word, [34:32] valid_bytes
  logic        s_tlast = 1'b0;  // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;  // [31:0] digest_word, [34:32] digest_index
  logic        m_tlast;  // last

  logic        steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned fails = 0;
  int unsigned words_checked = 0;
  int unsigned msgs_hashed = 0;

  // Predictor state
  logic [31:0] chain_h [DigestWords];
  logic [31:0] block_buf [BlockWords];
  logic [5:0]  byte_pos;
  logic [63:0] msg_bits;

  digest_beat_t digest_q [$];
  digest_beat_t want;

  sha1_hash_engine_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < DigestWords; i++) chain_h[i] = H_INIT[i];
    byte_pos = '0;
    msg_bits = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, t, k;
    for (int j = 0; j < 16; j++) w[j] = block_buf[j];
    for (int j = 16; j < 80; j++) w[j] = rol32(w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int j = 0; j < 80; j++) begin
      if (j < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (j < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (j < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol32(a, 5) + f + e + w[j] + k;
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void pack_byte(input logic [7:0] b);
    if (byte_pos[1:0] == 2'd0)
      block_buf[byte_pos[5:2]] = {b, 24'h0};
    else
      block_buf[byte_pos[5:2]] |= 32'(b) << (8 * (3 - int'(byte_pos[1:0])));
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) sha1_compress();
  endfunction

  // Fold one accepted beat into the running hash; queue the digest on end of message.
  function automatic void sha1_absorb_beat(input logic [31:0] data, input logic [2:0] cnt,
                                           input logic eom);
    int n;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (int i = 0; i < n; i++) begin
      pack_byte(data[31-8*i -: 8]);
      msg_bits += 64'd8;
    end
    if (!eom) return;
    pack_byte(PAD_BYTE);
    while (byte_pos != 6'd56) pack_byte(8'h00);
    block_buf[14] = msg_bits[63:32];
    block_buf[15] = msg_bits[31:0];
    byte_pos = '0;
    sha1_compress();
    for (int i = 0; i < DigestWords; i++)
      digest_q.push_back('{word: chain_h[i], idx: 3'(i), last: (i == DigestWords - 1)});
    sha1_restart();
  endfunction

  task automatic feed_beat(input logic [31:0] data, input logic [2:0] cnt, input logic eom);
    if (!steady)
      while ($urandom_range(99) < 35) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, cnt, data};
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    sha1_absorb_beat(data, cnt, eom);
    if (eom) msgs_hashed++;
  endtask

  task automatic drain_digests();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Check output beats against the oldest expectation; throttle the receiver.
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected: %h", m_tdata);
        fails++;
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[31:0] !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, m_tdata[31:0]);
          fails++;
        end
        if (m_tdata[34:32] !== want.idx) begin
          $error("digest_index: expected %0d, got %0d", want.idx, m_tdata[34:32]);
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_tlast);
          fails++;
        end
        words_checked++;
      end
    end
    m_tready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sha1_hash_engine_core: mismatch");
      $finish;
    end
  end

  initial begin
    msg_row_t    rows [$];
    int unsigned fed;
    int unsigned nwords;
    int unsigned r;
    logic [2:0]  cnt;
    bit          paused;

    sha1_restart();
    for (int i = 0; i < BlockWords; i++) block_buf[i] = '0;

    // Empty message, then "abc" in one partial word: digests known by heart.
    rows.push_back('{32'h00000000, 3'd0, 1'b1, 1'b1,
                     160'hda39a3ee5e6b4b0d3255bfef95601890afd80709});
    rows.push_back('{32'h61626300, 3'd3, 1'b1, 1'b1,
                     160'ha9993e364706816aba3e25717850c26c9cd0d89d});
    // Oversized count, idle beat, unaligned partial words, short tail with end flag
    rows.push_back('{32'hffffffff, 3'd7, 1'b0, 1'b0, 160'h0});
    rows.push_back('{32'h00000000, 3'd0, 1'b0, 1'b0, 160'h0});
    rows.push_back('{32'h12345678, 3'd2, 1'b0, 1'b0, 160'h0});
    rows.push_back('{32'haabbccdd, 3'd5, 1'b0, 1'b0, 160'h0});
    rows.push_back('{32'hffffffff, 3'd1, 1'b1, 1'b0, 160'h0});
    rows.push_back('{32'hdeadbeef, 3'd6, 1'b1, 1'b0, 160'h0});
    // 56-byte message: the length no longer fits, so padding spills into a second block
    for (int i = 0; i < 14; i++)
      rows.push_back('{32'h01010101 * i, 3'd4, (i == 13), 1'b0, 160'h0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      feed_beat(rows[i].data, rows[i].count, rows[i].eom);
      if (rows[i].known)
        for (int j = 0; j < DigestWords; j++)
          digest_q[digest_q.size() - DigestWords + j].word = rows[i].digest[159-32*j -: 32];
    end
    drain_digests();

    fed = 0;
    paused = 1'b0;
    while (fed < RandomBeats) begin
      steady <= (fed >= 50 && fed < 95);
      if (!paused && fed >= 110) begin
        drain_digests();
        paused = 1'b1;
      end
      // Mostly short messages; now and then a long one that usually spans two or more blocks
      nwords = ($urandom_range(99) < 10) ? $urandom_range(14, 34) : $urandom_range(0, 9);
      for (int w = 0; w < nwords; w++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          feed_beat($urandom, 3'd0, 1'b0);
          continue;
        end
        if (r < 14) cnt = 3'($urandom_range(1, 3));
        else if (r < 20) cnt = 3'($urandom_range(5, 7));
        else cnt = 3'd4;
        feed_beat($urandom, cnt, 1'b0);
        fed++;
      end
      feed_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
      fed++;
    end
    steady <= 1'b0;
    drain_digests();
    repeat (DrainCycles) @(posedge clk);

    $display("%0d messages hashed, %0d digest words checked, incl. two-block padding",
             msgs_hashed, words_checked);
    $display("random part fed %0d data beats with partial, oversized and idle beats", fed);
    if (fails == 0)
      $display("sha1_hash_engine_core: match");
    else
      $display("sha1_hash_engine_core: mismatch");
    $finish;
  end

endmodule
